>>> rtl/core/i2c_register_access_master_assert.svh
// ----------------------------------------------------------------------------
// I2C register access master: assertion macros
// Shared helpers so that every check is clocked and reset in the same way.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CRAM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c register access master: check failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c register access master: check failed");

`endif

>>> rtl/core/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Command codes, bus segment codes and the segment sequence tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cram_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    SEG_START   = 4'd0,
    SEG_STOP    = 4'd1,
    SEG_DEV_W   = 4'd2,
    SEG_REG     = 4'd3,
    SEG_DATA    = 4'd4,
    SEG_DEV_R   = 4'd5,
    SEG_ACK_IN  = 4'd6,
    SEG_RECV    = 4'd7,
    SEG_ACK_OUT = 4'd8
  } seg_t;

  localparam int unsigned POS_W = 4;
  localparam int unsigned OFF_W = 5;

  localparam logic [POS_W-1:0] LAST_POS_WR = 4'd7;
  localparam logic [POS_W-1:0] LAST_POS_RD = 4'd10;
  localparam logic [OFF_W-1:0] STOP_LAST_OFF = 5'd3;

  // Segment found at a given position of the write or read sequence.
  function automatic seg_t seg_at(input logic rd, input logic [POS_W-1:0] pos);
    seg_t s;
    s = SEG_STOP;
    if (rd) begin
      unique case (pos)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_DEV_W;
        4'd2:    s = SEG_ACK_IN;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_ACK_IN;
        4'd5:    s = SEG_START;
        4'd6:    s = SEG_DEV_R;
        4'd7:    s = SEG_ACK_IN;
        4'd8:    s = SEG_RECV;
        4'd9:    s = SEG_ACK_OUT;
        default: s = SEG_STOP;
      endcase
    end else begin
      unique case (pos)
        4'd0:    s = SEG_START;
        4'd1:    s = SEG_DEV_W;
        4'd2:    s = SEG_ACK_IN;
        4'd3:    s = SEG_REG;
        4'd4:    s = SEG_ACK_IN;
        4'd5:    s = SEG_DATA;
        4'd6:    s = SEG_ACK_IN;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

  // Offset of the final micro-op within a segment.
  function automatic logic [OFF_W-1:0] seg_last_off(input seg_t s);
    logic [OFF_W-1:0] v;
    v = 5'd3;
    unique case (s)
      SEG_DEV_W, SEG_REG, SEG_DATA, SEG_DEV_R: v = 5'd23;
      SEG_RECV:                                v = 5'd24;
      SEG_ACK_OUT:                             v = 5'd2;
      default:                                 v = 5'd3;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// I2C register access master
// Single-register write and read over open-drain SCL and SDA, one tick per
// input transaction.
// ----------------------------------------------------------------------------
// Every input transaction is one timing tick. A tick on an idle block with a
// write or read command latches the register address and data and starts the
// bus sequence; other commands, and all commands while busy, just tick.
// Each pin step is held for hold_ticks ticks. Every input transaction yields
// exactly one result transaction carrying the line drives, busy, the done
// pulse, the last read byte and the sticky NACK flag.
// The sequencer step and the result are registered together, so the result
// appears in the cycle after its tick; a new tick is taken every cycle unless
// the receiver stalls. When it stalls, the held result stays put and in_stall
// rises in the same cycle, so no tick is lost or repeated.
// The configuration port writes device_address (index 0) and hold_ticks
// (index 1); the user must use it only while no transaction is running, as
// the block does not enforce this. Reset returns the block to idle with both
// lines released, device address 104 and a hold of five ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_reg_addr,
  input  wire logic [7:0] in_write_data,
  input  wire logic       in_sda_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl_out,
  output logic            out_sda_out,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic [7:0]      out_read_data,
  output logic            out_nack_seen
);

  logic [6:0]       dev_addr_r;
  logic [7:0]       hold_ticks_r;

  logic             busy_r, busy_nxt;
  logic             is_read_r, is_read_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       lat_reg_r, lat_reg_nxt;
  logic [7:0]       lat_data_r, lat_data_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic [7:0]       rx_byte_r, rx_byte_nxt;
  logic             nack_r, nack_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_busy_r, out_busy_nxt;
  logic             out_done_r, out_done_nxt;

  logic             in_acc;
  logic             start;
  logic             advance;
  logic             apply;
  logic [7:0]       reload;
  seg_t             cur_seg;
  seg_t             seg;
  logic [7:0]       load_byte;
  logic [POS_W-1:0] last_pos;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign reload = (hold_ticks_r == 8'd0) ? 8'd0 : hold_ticks_r - 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= 7'd104;
      hold_ticks_r <= 8'd5;
    end else if (cfg_we) begin
      if (cfg_index) begin
        hold_ticks_r <= cfg_data;
      end else begin
        dev_addr_r <= cfg_data[6:0];
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    is_read_nxt   = is_read_r;
    pos_nxt       = pos_r;
    off_nxt       = off_r;
    sub_nxt       = sub_r;
    bit_nxt       = bit_r;
    hold_nxt      = hold_r;
    shift_nxt     = shift_r;
    lat_reg_nxt   = lat_reg_r;
    lat_data_nxt  = lat_data_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    rx_byte_nxt   = rx_byte_r;
    nack_nxt      = nack_r;
    out_busy_nxt  = out_busy_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    load_byte     = shift_r;

    start   = in_acc & ~busy_r &
              ((in_command == CMD_WRITE) || (in_command == CMD_READ));
    advance = in_acc & busy_r & (hold_r == 8'd0);
    apply   = start | advance;
    cur_seg = seg_at(is_read_r, pos_r);

    if (start) begin
      is_read_nxt  = (in_command == CMD_READ);
      lat_reg_nxt  = in_reg_addr;
      lat_data_nxt = in_write_data;
      nack_nxt     = 1'b0;
      busy_nxt     = 1'b1;
      pos_nxt      = '0;
      off_nxt      = '0;
      sub_nxt      = '0;
      bit_nxt      = '0;
    end else if (advance) begin
      if (off_r == seg_last_off(cur_seg)) begin
        pos_nxt = pos_r + 4'd1;
        off_nxt = '0;
        sub_nxt = '0;
        bit_nxt = '0;
      end else begin
        off_nxt = off_r + 5'd1;
        // The receive segment spends its first micro-op releasing SDA,
        // so its bit counting starts one offset later.
        if ((cur_seg == SEG_RECV) && (off_r == 5'd0)) begin
          sub_nxt = '0;
          bit_nxt = '0;
        end else if (sub_r == 2'd2) begin
          sub_nxt = '0;
          bit_nxt = bit_r + 3'd1;
        end else begin
          sub_nxt = sub_r + 2'd1;
        end
      end
    end

    seg      = seg_at(is_read_nxt, pos_nxt);
    last_pos = is_read_nxt ? LAST_POS_RD : LAST_POS_WR;

    if (apply) begin
      hold_nxt = reload;
      unique case (seg)
        SEG_START: begin
          unique case (off_nxt[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        SEG_STOP: begin
          unique case (off_nxt[1:0])
            2'd0:    scl_nxt = 1'b0;
            2'd1:    sda_nxt = 1'b0;
            2'd2:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
        SEG_DEV_W, SEG_REG, SEG_DATA, SEG_DEV_R: begin
          if (off_nxt == 5'd0) begin
            unique case (seg)
              SEG_DEV_W: load_byte = {dev_addr_r, 1'b0};
              SEG_DEV_R: load_byte = {dev_addr_r, 1'b1};
              SEG_REG:   load_byte = lat_reg_nxt;
              default:   load_byte = lat_data_nxt;
            endcase
          end
          shift_nxt = load_byte;
          unique case (sub_nxt)
            2'd0: sda_nxt = load_byte[7];
            2'd1: scl_nxt = 1'b1;
            default: begin
              scl_nxt   = 1'b0;
              shift_nxt = {load_byte[6:0], 1'b0};
            end
          endcase
        end
        SEG_ACK_IN: begin
          unique case (off_nxt[1:0])
            2'd0:    sda_nxt  = 1'b1;
            2'd1:    scl_nxt  = 1'b1;
            2'd2:    nack_nxt = nack_r | in_sda_in;
            default: scl_nxt  = 1'b0;
          endcase
        end
        SEG_RECV: begin
          if (off_nxt == 5'd0) begin
            sda_nxt   = 1'b1;
            shift_nxt = '0;
          end else begin
            unique case (sub_nxt)
              2'd0: scl_nxt = 1'b1;
              2'd1: begin
                shift_nxt = {shift_r[6:0], in_sda_in};
                if (bit_nxt == 3'd7) begin
                  rx_byte_nxt = {shift_r[6:0], in_sda_in};
                end
              end
              default: scl_nxt = 1'b0;
            endcase
          end
        end
        default: begin
          // Master answers the read byte with a NACK.
          unique case (off_nxt[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
      endcase
    end else if (in_acc && busy_r) begin
      hold_nxt = hold_r - 8'd1;
    end

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_busy_nxt  = start | busy_r;
      out_done_nxt  = (start | busy_r) && (pos_nxt == last_pos) &&
                      (off_nxt == STOP_LAST_OFF) && (hold_nxt == 8'd0);
      if (out_done_nxt) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      is_read_r   <= 1'b0;
      pos_r       <= '0;
      off_r       <= '0;
      sub_r       <= '0;
      bit_r       <= '0;
      hold_r      <= '0;
      shift_r     <= '0;
      lat_reg_r   <= '0;
      lat_data_r  <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      rx_byte_r   <= '0;
      nack_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_busy_r  <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      is_read_r   <= is_read_nxt;
      pos_r       <= pos_nxt;
      off_r       <= off_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      hold_r      <= hold_nxt;
      shift_r     <= shift_nxt;
      lat_reg_r   <= lat_reg_nxt;
      lat_data_r  <= lat_data_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      rx_byte_r   <= rx_byte_nxt;
      nack_r      <= nack_nxt;
      out_valid_r <= out_valid_nxt;
      out_busy_r  <= out_busy_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  // Line levels, read byte and NACK flag change only when a tick is taken,
  // so the state registers double as the result payload.
  assign out_valid     = out_valid_r;
  assign out_scl_out   = scl_r;
  assign out_sda_out   = sda_r;
  assign out_busy_res  = out_busy_r;
  assign out_done_res  = out_done_r;
  assign out_read_data = rx_byte_r;
  assign out_nack_seen = nack_r;

`include "i2c_register_access_master_assert.svh"

  `I2CRAM_ASSERT_SAME(a_done_implies_busy, out_valid && out_done_res, out_busy_res)
  `I2CRAM_ASSERT_NEXT(a_idle_tick_stays_idle,
    in_acc && !busy_r && (in_command != CMD_WRITE) && (in_command != CMD_READ),
    !out_busy_res && !out_done_res && !busy_r)
  `I2CRAM_ASSERT_NEXT(a_final_stop_ends_sequence,
    in_acc && busy_r && (hold_r == 8'd0) && (off_r == STOP_LAST_OFF) &&
    (pos_r == (is_read_r ? LAST_POS_RD : LAST_POS_WR)),
    !busy_r && out_done_res)

endmodule

`default_nettype wire
